// File: rtl/sab_pkg.sv
// Shared constants and types for the suffix automaton builder.
package sab_pkg;
  localparam int MaxText  = 1024;
  localparam int Alphabet = 26;
  localparam int NStates  = 2 * MaxText;
  localparam int SW       = $clog2(NStates);
  localparam int AW       = $clog2(Alphabet);
  localparam int TW       = $clog2(NStates * Alphabet);

  typedef logic [SW-1:0] state_idx_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LEN_RD,
    ST_LEN_WAIT,
    ST_WALK_RD,
    ST_WALK_WAIT,
    ST_WALK_CHK,
    ST_LINK_WAIT,
    ST_Q_WAIT,
    ST_CLONE_RD,
    ST_CLONE_WR,
    ST_QLINK_WAIT,
    ST_RED_RD,
    ST_RED_WAIT,
    ST_RED_LINK,
    ST_DONE
  } sab_state_t;

  function automatic logic [TW-1:0] tt_addr(input state_idx_t st, input logic [AW-1:0] sym);
    tt_addr = TW'(st) * TW'(Alphabet) + TW'(sym);
  endfunction
endpackage

// File: rtl/suffix_automaton_builder.sv
// Suffix automaton builder: online construction, one symbol per accepted word.
// Each input word carries one letter and yields one result word. The
// transition table (2048 states x 26 letters), suffix links and longest
// lengths sit in three single-port synchronous memories with registered
// read data. A symbol reads the last state's length, writes the new
// state's length and link, walks the suffix links, copies all 26
// transitions when a clone is made, then redirects edges to the clone.
// After reset a clearing pass sweeps the transition table (the link and
// length stores are cleared alongside from the low sweep counter bits);
// no symbol is accepted during it. A finished result sits in an output
// register; hold off the next symbol until that word is taken.
module suffix_automaton_builder (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [4:0] symbol
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [23:0] m_tdata   // [10:0] last_state, [21:11] state_count, [22] overflow
);
  localparam int SW = sab_pkg::SW;
  localparam int TW = sab_pkg::TW;
  localparam int AW = sab_pkg::AW;

  logic [SW-1:0] tt_mem [0:sab_pkg::NStates*sab_pkg::Alphabet-1];
  logic [SW-1:0] lk_mem [0:sab_pkg::NStates-1];
  logic [SW-1:0] ln_mem [0:sab_pkg::NStates-1];

  // memory ports
  logic          tt_we, lk_we, ln_we;
  logic [TW-1:0] tt_a;
  logic [SW-1:0] lk_a, ln_a, tt_wd, lk_wd, ln_wd, tt_rd, lk_rd, ln_rd;

  always_ff @(posedge clk) begin
    if (tt_we) tt_mem[tt_a] <= tt_wd;
    tt_rd <= tt_mem[tt_a];
  end
  always_ff @(posedge clk) begin
    if (lk_we) lk_mem[lk_a] <= lk_wd;
    lk_rd <= lk_mem[lk_a];
  end
  always_ff @(posedge clk) begin
    if (ln_we) ln_mem[ln_a] <= ln_wd;
    ln_rd <= ln_mem[ln_a];
  end

  sab_pkg::sab_state_t state, state_next;
  logic          clearing;
  logic [TW-1:0] clr_cnt;
  logic [AW-1:0] sym, sym_next, ci, ci_next;
  logic [SW-1:0] last, last_next, cnt, cnt_next, p, p_next, np, np_next;
  logic [SW-1:0] q, q_next, nq, nq_next, plen, plen_next, cv, cv_next;
  logic          ovf_next, m_load;
  logic [SW-1:0] res_last, res_cnt;
  logic          res_ovf;

  logic [4:0] in_sym;
  assign in_sym = s_tdata[4:0];
  assign s_tready = (state == sab_pkg::ST_IDLE) && !clearing && !m_tvalid;

  // clearing sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      if (clr_cnt == TW'(sab_pkg::NStates * sab_pkg::Alphabet - 1)) clearing <= 1'b0;
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sab_pkg::ST_IDLE;
      last  <= '0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      last  <= last_next;
      cnt   <= cnt_next;
    end
    sym <= sym_next; p <= p_next; np <= np_next; q <= q_next; nq <= nq_next;
    plen <= plen_next; ci <= ci_next; cv <= cv_next;
  end

  always_comb begin
    state_next = state;
    last_next = last; cnt_next = cnt; sym_next = sym; p_next = p; np_next = np;
    q_next = q; nq_next = nq; plen_next = plen; ci_next = ci; cv_next = cv;
    ovf_next = 1'b0; m_load = 1'b0;
    tt_we = 1'b0; lk_we = 1'b0; ln_we = 1'b0;
    tt_a = sab_pkg::tt_addr(p, sym); lk_a = p; ln_a = p;
    tt_wd = np; lk_wd = '0; ln_wd = '0;
    if (clearing) begin
      tt_we = 1'b1; tt_a = clr_cnt; tt_wd = '0;
      lk_we = 1'b1; lk_a = clr_cnt[SW-1:0];
      ln_we = 1'b1; ln_a = clr_cnt[SW-1:0];
    end else begin
      case (state)
        sab_pkg::ST_IDLE: begin
          if (s_tvalid && s_tready) begin
            if (in_sym >= 5'(sab_pkg::Alphabet)) begin
              m_load = 1'b1;
            end else if ({1'b0, cnt} + 12'd2 >= 12'(sab_pkg::NStates)) begin
              m_load = 1'b1; ovf_next = 1'b1;
            end else begin
              sym_next = in_sym[AW-1:0];
              p_next = last;
              np_next = cnt + 1'b1;
              cnt_next = cnt + 1'b1;
              state_next = sab_pkg::ST_LEN_RD;
            end
          end
        end
        sab_pkg::ST_LEN_RD: begin
          ln_a = p; state_next = sab_pkg::ST_LEN_WAIT;
        end
        sab_pkg::ST_LEN_WAIT: begin
          ln_we = 1'b1; ln_a = np; ln_wd = ln_rd + 1'b1;
          lk_we = 1'b1; lk_a = np; lk_wd = '0;
          state_next = sab_pkg::ST_WALK_RD;
        end
        sab_pkg::ST_WALK_RD: begin
          // read edge(p,sym), link(p), len(p) together
          state_next = sab_pkg::ST_WALK_WAIT;
        end
        sab_pkg::ST_WALK_WAIT: begin
          plen_next = ln_rd;
          q_next = tt_rd;
          cv_next = lk_rd;
          state_next = sab_pkg::ST_WALK_CHK;
        end
        sab_pkg::ST_WALK_CHK: begin
          if (q == '0) begin
            tt_we = 1'b1;
            if (p != '0) begin
              p_next = cv; state_next = sab_pkg::ST_WALK_RD;
            end else begin
              lk_we = 1'b1; lk_a = np; lk_wd = p;
              state_next = sab_pkg::ST_DONE;
            end
          end else begin
            ln_a = q; state_next = sab_pkg::ST_Q_WAIT;
          end
        end
        sab_pkg::ST_Q_WAIT: begin
          if (ln_rd == plen + 1'b1) begin
            lk_we = 1'b1; lk_a = np; lk_wd = q;
            state_next = sab_pkg::ST_DONE;
          end else begin
            nq_next = cnt + 1'b1; cnt_next = cnt + 1'b1;
            ci_next = '0;
            state_next = sab_pkg::ST_CLONE_RD;
          end
        end
        sab_pkg::ST_CLONE_RD: begin
          tt_a = sab_pkg::tt_addr(q, ci);
          state_next = sab_pkg::ST_CLONE_WR;
        end
        sab_pkg::ST_CLONE_WR: begin
          tt_we = 1'b1; tt_a = sab_pkg::tt_addr(nq, ci); tt_wd = tt_rd;
          if (ci == AW'(sab_pkg::Alphabet - 1)) begin
            lk_a = q; state_next = sab_pkg::ST_LINK_WAIT;
          end else begin
            ci_next = ci + 1'b1; state_next = sab_pkg::ST_CLONE_RD;
          end
        end
        sab_pkg::ST_LINK_WAIT: begin
          lk_we = 1'b1; lk_a = nq; lk_wd = lk_rd;
          ln_we = 1'b1; ln_a = nq; ln_wd = plen + 1'b1;
          state_next = sab_pkg::ST_QLINK_WAIT;
        end
        sab_pkg::ST_QLINK_WAIT: begin
          lk_we = 1'b1; lk_a = q; lk_wd = nq;
          state_next = sab_pkg::ST_RED_LINK;
        end
        sab_pkg::ST_RED_LINK: begin
          lk_we = 1'b1; lk_a = np; lk_wd = nq;
          state_next = sab_pkg::ST_RED_RD;
        end
        sab_pkg::ST_RED_RD: begin
          state_next = sab_pkg::ST_RED_WAIT;
        end
        sab_pkg::ST_RED_WAIT: begin
          if (tt_rd == q) begin
            tt_we = 1'b1; tt_wd = nq;
            p_next = lk_rd; state_next = sab_pkg::ST_RED_RD;
          end else begin
            state_next = sab_pkg::ST_DONE;
          end
        end
        sab_pkg::ST_DONE: begin
          last_next = np; m_load = 1'b1;
          state_next = sab_pkg::ST_IDLE;
        end
        default: state_next = sab_pkg::ST_IDLE;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (m_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (m_load) begin
      res_last <= last_next;
      res_cnt  <= cnt_next;
      res_ovf  <= ovf_next;
    end
  end

  assign m_tdata = {1'b0, res_ovf, res_cnt, res_last};

  // new state index always equal to the allocated count
  a_np: assert property (@(posedge clk) disable iff (rst)
    (state == sab_pkg::ST_LEN_RD) |-> (np == cnt)) else $error("np mismatch");
  // no input taken during the clearing sweep
  a_clr: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s_tready) else $error("accept while clearing");
  // a result is loaded only when the output is free
  a_out: assert property (@(posedge clk) disable iff (rst)
    m_load |-> !m_tvalid) else $error("result overwritten");
endmodule

// File: sim/suffix_automaton_builder_test.sv
// Testbench for the suffix automaton builder: predicted results checked word by word.
`timescale 1ns / 1ps

module suffix_automaton_builder_test;

  localparam int StoreSize = sab_pkg::NStates;
  localparam longint CycleLimit = 64'd4000000;

  typedef struct packed {
    logic                overflow;
    sab_pkg::state_idx_t state_count;
    sab_pkg::state_idx_t last_state;
  } sam_result_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;

  suffix_automaton_builder DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  // Predictor copy of the automaton
  int unsigned sam_next[StoreSize][sab_pkg::Alphabet];
  int unsigned sam_link[StoreSize];
  int unsigned sam_len[StoreSize];
  int unsigned sam_last;
  int unsigned sam_count;

  sam_result_t pending_results[$];
  int          mismatches;
  int          stray_results;
  longint      cycle_count;
  bit          stall_enable;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Online extension step of the automaton, mirrored from the block's behavior.
  function automatic void sam_extend(input int unsigned sym);
    int unsigned np, p, q, nq, guard;
    sam_count++;
    np = sam_count;
    p = sam_last;
    guard = 0;
    sam_len[np] = sam_len[p] + 1;
    sam_link[np] = 0;
    while (p != 0 && sam_next[p][sym] == 0 && guard < StoreSize) begin
      sam_next[p][sym] = np;
      p = sam_link[p] % StoreSize;
      guard++;
    end
    if (sam_next[p][sym] == 0) begin
      sam_next[p][sym] = np;
      sam_link[np] = p;
    end else begin
      q = sam_next[p][sym] % StoreSize;
      if (sam_len[q] == sam_len[p] + 1) begin
        sam_link[np] = q;
      end else begin
        sam_count++;
        nq = sam_count;
        for (int a = 0; a < sab_pkg::Alphabet; a++) sam_next[nq][a] = sam_next[q][a];
        sam_link[nq] = sam_link[q];
        sam_len[nq] = sam_len[p] + 1;
        sam_link[np] = nq;
        sam_link[q] = nq;
        guard = 0;
        while (sam_next[p][sym] == q && guard < StoreSize) begin
          sam_next[p][sym] = nq;
          p = sam_link[p] % StoreSize;
          guard++;
        end
      end
    end
    sam_last = np;
  endfunction

  function automatic sam_result_t predict_symbol(input logic [4:0] sym);
    sam_result_t r;
    r.overflow = 1'b0;
    if (sym < sab_pkg::Alphabet) begin
      if (sam_count + 2 >= StoreSize) r.overflow = 1'b1;
      else sam_extend(sym);
    end
    r.last_state  = sab_pkg::state_idx_t'(sam_last);
    r.state_count = sab_pkg::state_idx_t'(sam_count);
    return r;
  endfunction

  function automatic int gap_length();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 2);
  endfunction

  // Send one word; the expectation is queued before the handshake completes.
  task automatic send_symbol(input logic [4:0] sym);
    int gap;
    gap = stall_enable ? gap_length() : 0;
    repeat (gap) @(posedge clk);
    pending_results.push_back(predict_symbol(sym));
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, sym};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    s_tvalid <= 1'b0;
    // the block cannot take a word on the edge right after an accept
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Receiver: random backpressure on the master side.
  initial begin
    int hold;
    m_tready = 1'b0;
    @(negedge rst);
    m_tready <= 1'b1;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) begin
        hold = stall_enable ? gap_length() : 0;
        if (hold != 0) begin
          m_tready <= 1'b0;
          repeat (hold) @(posedge clk);
          m_tready <= 1'b1;
        end
      end
    end
  end

  // Check each accepted result word against the oldest expectation.
  always @(posedge clk) begin
    sam_result_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = sam_result_t'(m_tdata[22:0]);
      if (pending_results.size() == 0) begin
        stray_results++;
        if (mismatches + stray_results <= 10)
          $display("unexpected result word %h", m_tdata);
      end else begin
        want = pending_results.pop_front();
        if (got !== want || m_tdata[23] !== 1'b0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: last %0d/%0d count %0d/%0d ovf %0d/%0d (exp/got)",
                     want.last_state, got.last_state, want.state_count,
                     got.state_count, want.overflow, got.overflow);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic test_directed();
    // extremes, repeats that force clones, and out-of-range symbols
    send_symbol(5'd0);
    send_symbol(5'd25);
    send_symbol(5'd0);
    send_symbol(5'd0);
    send_symbol(5'd0);
    send_symbol(5'd25);
    send_symbol(5'd0);
    send_symbol(5'd26);
    send_symbol(5'd31);
    send_symbol(5'd1);
    send_symbol(5'd0);
    send_symbol(5'd1);
    send_symbol(5'd30);
    send_symbol(5'd0);
  endtask

  task automatic test_random_text();
    int k;
    for (k = 0; k < 300; k++) begin
      if ($urandom_range(0, 19) == 0) send_symbol(5'($urandom_range(26, 31)));
      else if (k % 100 < 50) send_symbol(5'($urandom_range(0, 2)));
      else send_symbol(5'($urandom_range(0, 25)));
      if (k == 150) wait_drained();
    end
  endtask

  task automatic test_store_full();
    // run until the store refuses symbols, then keep pushing a few more
    stall_enable = 1'b0;
    while (sam_count + 2 < StoreSize) send_symbol(5'($urandom_range(0, 1)));
    stall_enable = 1'b1;
    repeat (20) send_symbol(5'($urandom_range(0, 31)));
  endtask

  initial begin
    for (int s = 0; s < StoreSize; s++) begin
      sam_link[s] = 0;
      sam_len[s] = 0;
      for (int a = 0; a < sab_pkg::Alphabet; a++) sam_next[s][a] = 0;
    end
    sam_last = 0;
    sam_count = 0;
    mismatches = 0;
    stray_results = 0;
    cycle_count = 0;
    stall_enable = 1'b1;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = 8'd0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_text();
    test_store_full();
    wait_drained();
    repeat (200) @(posedge clk);
    if (mismatches == 0 && stray_results == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

// File: suffix_automaton_builder.f
rtl/sab_pkg.sv
rtl/suffix_automaton_builder.sv
sim/suffix_automaton_builder_test.sv
